// ===== src/tcce_pkg.sv =====
// Types, constants and glyph mapping for the text console cursor engine.
`timescale 1ns / 1ps
package tcce_pkg;

	localparam int MAX_SCREEN_DIM = 4096;
	localparam int MARGIN_PX      = 8;

	localparam int CUR_W = 13;
	localparam int SUM_W = 15;
	localparam int CP_W  = 11;
	localparam int POS_W = 12;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_SCALE  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_DRAW  = 1'b0,
		ACT_CLEAR = 1'b1
	} action_t;

	typedef enum logic {
		TBL_LATIN    = 1'b0,
		TBL_CYRILLIC = 1'b1
	} glyph_tbl_t;

	localparam logic [CP_W-1:0] CP_LF = 11'h00A;
	localparam logic [CP_W-1:0] CP_CR = 11'h00D;
	localparam logic [5:0] IDX_QUESTION = 6'h1F;
	localparam logic [5:0] IDX_YO       = 6'd32;

	typedef struct packed {
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_x;
		logic [5:0]       glyph_index;
		glyph_tbl_t       glyph_table;
		action_t          action;
		logic             last;
	} result_t;

	typedef struct packed {
		glyph_tbl_t tbl;
		logic [5:0] idx;
	} glyph_t;

	function automatic glyph_t map_glyph(input logic [CP_W-1:0] cp_in);
		logic [CP_W-1:0] cp;
		glyph_t g;
		cp = cp_in;
		g.tbl = TBL_LATIN;
		g.idx = IDX_QUESTION;
		if (cp >= 11'h061 && cp <= 11'h07A) begin
			cp = cp - 11'h020;
		end
		if (cp >= 11'h020 && cp <= 11'h05F) begin
			g.tbl = TBL_LATIN;
			g.idx = 6'(cp - 11'h020);
		end else begin
			if (cp >= 11'h430 && cp <= 11'h44F) begin
				cp = cp - 11'h020;
			end
			if (cp >= 11'h410 && cp <= 11'h42F) begin
				g.tbl = TBL_CYRILLIC;
				g.idx = 6'(cp - 11'h410);
			end else if (cp == 11'h401 || cp == 11'h451) begin
				g.tbl = TBL_CYRILLIC;
				g.idx = IDX_YO;
			end
		end
		return g;
	endfunction

endpackage

// ===== src/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: UTF-8 decode, cursor and result queue.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one console byte per word (tdata[7:0]). m_axis carries
//   draw and clear commands; tlast marks the final command caused by a byte.
//   cfg_we/cfg_addr/cfg_wdata write the enable, width, height and scale
//   registers; write them only while no byte is in flight.
// Flow: a byte is registered into byte_s1 on accept and decoded from there;
//   its commands are written into the result queue, which drives m_axis,
//   once two queue entries are free.
// Throughput: one byte per cycle while two queue entries are free. A byte yields zero,
//   one or two commands; the output queue (four entries) drains one command per cycle
//   while m_axis_tready is high, so a run of two-command bytes is limited by m_axis.
// Reset: config returns to enabled, 720x1280, scale 2; cursor to the margin;
//   any held lead byte and all queued commands are dropped.
// Stall: while m_axis is stalled the queue fills; the held byte waits until
//   two entries are free, and s_axis_tready falls once that stage is full.
module text_console_cursor_engine
	import tcce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [0] action, [1] glyph_table, [7:2] glyph_index,
	                                   // [19:8] pos_x, [31:20] pos_y
	output logic        m_axis_tlast
);

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int CNT_W = 3;
	localparam logic [CUR_W-1:0] MARGIN = CUR_W'(MARGIN_PX);

	logic             enable_q;
	logic [12:0]      width_q;
	logic [12:0]      height_q;
	logic [4:0]       scale_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             lead_valid_q;
	logic [4:0]       lead_q;
	logic [CUR_W-1:0] cursor_x_q;
	logic [CUR_W-1:0] cursor_y_q;

	result_t          fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic             fire_s1;
	logic             pop;
	logic             is_cont;
	logic             is_lead;
	logic             do_cp;
	logic [CP_W-1:0]  cp;
	logic [7:0]       cell_px;
	logic [SUM_W-1:0] w_sat;
	logic [SUM_W-1:0] h_sat;
	logic             is_cr;
	logic             is_lf;
	logic             wrap;
	logic             full;
	logic [CUR_W-1:0] x1;
	logic [CUR_W-1:0] y1;
	logic [CUR_W-1:0] x2;
	logic [CUR_W-1:0] y2;
	logic [CUR_W-1:0] x_nxt;
	logic [CUR_W-1:0] y_nxt;
	logic             lead_valid_nxt;
	logic [4:0]       lead_nxt;
	glyph_t           glyph;
	result_t          res0;
	result_t          res1;
	logic [1:0]       push_n;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			width_q  <= 13'd720;
			height_q <= 13'd1280;
			scale_q  <= 5'd2;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_WIDTH:  width_q  <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				REG_SCALE:  scale_q  <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	assign fire_s1       = valid_s1 && (count_q <= CNT_W'(DEPTH - 2));
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		is_cont = lead_valid_q && (byte_s1[7:6] == 2'b10);
		is_lead = (byte_s1 >= 8'hC0) && (byte_s1 <= 8'hDF);
		lead_valid_nxt = lead_valid_q;
		lead_nxt = lead_q;
		do_cp = 1'b0;
		cp = {3'b000, byte_s1};
		if (is_cont) begin
			lead_valid_nxt = 1'b0;
			do_cp = 1'b1;
			cp = {lead_q, byte_s1[5:0]};
		end else if (is_lead) begin
			lead_valid_nxt = 1'b1;
			lead_nxt = byte_s1[4:0];
		end else begin
			lead_valid_nxt = 1'b0;
			do_cp = (byte_s1 < 8'hE0);
		end
	end

	always_comb begin
		cell_px = {((scale_q == 5'd0) ? 5'd1 : scale_q), 3'b000};
		w_sat = (SUM_W'(width_q) > SUM_W'(MAX_SCREEN_DIM)) ?
			SUM_W'(MAX_SCREEN_DIM) : SUM_W'(width_q);
		h_sat = (SUM_W'(height_q) > SUM_W'(MAX_SCREEN_DIM)) ?
			SUM_W'(MAX_SCREEN_DIM) : SUM_W'(height_q);
		is_cr = (cp == CP_CR);
		is_lf = (cp == CP_LF);
		wrap  = !is_lf &&
			(SUM_W'(cursor_x_q) + SUM_W'(cell_px) + SUM_W'(MARGIN_PX) > w_sat);
		x1 = (is_lf || wrap) ? MARGIN : cursor_x_q;
		y1 = (is_lf || wrap) ? CUR_W'(cursor_y_q + CUR_W'(cell_px)) : cursor_y_q;
		full = SUM_W'(y1) + SUM_W'(cell_px) + SUM_W'(MARGIN_PX) > h_sat;
		x2 = full ? MARGIN : x1;
		y2 = full ? MARGIN : y1;
		glyph = map_glyph(cp);

		res0 = '0;
		res0.action = ACT_CLEAR;
		res0.glyph_table = TBL_LATIN;
		res0.last = is_lf;
		res1.action = ACT_DRAW;
		res1.glyph_table = glyph.tbl;
		res1.glyph_index = glyph.idx;
		res1.pos_x = x2[POS_W-1:0];
		res1.pos_y = y2[POS_W-1:0];
		res1.last = 1'b1;

		x_nxt = cursor_x_q;
		y_nxt = cursor_y_q;
		push_n = 2'd0;
		if (do_cp) begin
			if (is_cr) begin
				x_nxt = MARGIN;
			end else if (is_lf) begin
				x_nxt = x2;
				y_nxt = y2;
				push_n = full ? 2'd1 : 2'd0;
			end else begin
				x_nxt = CUR_W'(x2 + CUR_W'(cell_px));
				y_nxt = y2;
				push_n = full ? 2'd2 : 2'd1;
				if (!full) begin
					res0 = res1;
				end
			end
		end
		if (!fire_s1 || !enable_q) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_valid_q <= 1'b0;
			lead_q       <= '0;
			cursor_x_q   <= MARGIN;
			cursor_y_q   <= MARGIN;
		end else if (fire_s1 && enable_q) begin
			lead_valid_q <= lead_valid_nxt;
			lead_q       <= lead_nxt;
			cursor_x_q   <= x_nxt;
			cursor_y_q   <= y_nxt;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			fifo_q[PTR_W'(wr_ptr_q + 1'b1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push_n));
			rd_ptr_q <= PTR_W'(rd_ptr_q + PTR_W'(pop));
			count_q  <= CNT_W'(count_q + CNT_W'(push_n) - CNT_W'(pop));
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {fifo_q[rd_ptr_q].pos_y, fifo_q[rd_ptr_q].pos_x,
		fifo_q[rd_ptr_q].glyph_index, fifo_q[rd_ptr_q].glyph_table,
		fifo_q[rd_ptr_q].action};
	assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not drop on pop");

	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !enable_q && !cfg_we) |=>
			($stable(cursor_x_q) && $stable(cursor_y_q) && $stable(lead_valid_q)))
		else $error("state changed while console disabled");

	a_two_only_with_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (res0.action == ACT_CLEAR && res1.action == ACT_DRAW))
		else $error("double push without clear then draw");

endmodule

// ===== tb/testbench.sv =====
// Scoreboard and stimulus for the text console cursor engine: UTF-8 bytes in, draw/clear commands out.
`timescale 1ns / 1ps
import tcce_pkg::*;

class glyph_cmd_scoreboard;
	bit          enabled;
	bit [12:0]   scr_w;
	bit [12:0]   scr_h;
	bit [4:0]    scale;
	bit [7:0]    lead;
	int          cur_x;
	int          cur_y;
	result_t     cmd_q[$];
	int          errors;
	int          checked;
	int          clears;

	function new();
		enabled = 1'b1;
		scr_w   = 13'd720;
		scr_h   = 13'd1280;
		scale   = 5'd2;
		lead    = 8'h00;
		cur_x   = MARGIN_PX;
		cur_y   = MARGIN_PX;
	endfunction

	function void write_reg(cfg_reg_t r, bit [12:0] v);
		case (r)
			REG_ENABLE: enabled = v[0];
			REG_WIDTH:  scr_w = v;
			REG_HEIGHT: scr_h = v;
			REG_SCALE:  scale = v[4:0];
			default: ;
		endcase
	endfunction

	function void push_cmd(action_t act, glyph_tbl_t tbl, bit [5:0] idx,
	                       bit [11:0] px, bit [11:0] py, bit fin);
		result_t c;
		c.action      = act;
		c.glyph_table = tbl;
		c.glyph_index = idx;
		c.pos_x       = px;
		c.pos_y       = py;
		c.last        = fin;
		cmd_q.push_back(c);
	endfunction

	function void emit_codepoint(bit [10:0] cp);
		int         w;
		int         h;
		int         cell_px;
		bit [10:0]  f;
		glyph_tbl_t tbl;
		bit [5:0]   idx;
		w       = (scr_w > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : int'(scr_w);
		h       = (scr_h > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : int'(scr_h);
		cell_px = 8 * ((scale == 0) ? 1 : int'(scale));
		if (cp == CP_CR) begin
			cur_x = MARGIN_PX;
			return;
		end
		if (cp == CP_LF || cur_x + cell_px + MARGIN_PX > w) begin
			cur_x = MARGIN_PX;
			cur_y = (cur_y + cell_px) & 'h1FFF;
		end
		if (cur_y + cell_px + MARGIN_PX > h) begin
			cur_x = MARGIN_PX;
			cur_y = MARGIN_PX;
			push_cmd(ACT_CLEAR, TBL_LATIN, 6'd0, 12'd0, 12'd0, cp == CP_LF);
		end
		if (cp == CP_LF)
			return;
		f   = cp;
		tbl = TBL_LATIN;
		idx = IDX_QUESTION;
		if (f >= 11'h061 && f <= 11'h07A)
			f = f - 11'h020;
		if (f >= 11'h020 && f <= 11'h05F) begin
			idx = 6'(f - 11'h020);
		end else begin
			if (f >= 11'h430 && f <= 11'h44F)
				f = f - 11'h020;
			if (f >= 11'h410 && f <= 11'h42F) begin
				tbl = TBL_CYRILLIC;
				idx = 6'(f - 11'h410);
			end else if (f == 11'h401 || f == 11'h451) begin
				tbl = TBL_CYRILLIC;
				idx = IDX_YO;
			end
		end
		push_cmd(ACT_DRAW, tbl, idx, 12'(cur_x), 12'(cur_y), 1'b1);
		cur_x = (cur_x + cell_px) & 'h1FFF;
	endfunction

	function void note_byte(bit [7:0] b);
		bit [7:0] held;
		if (!enabled)
			return;
		if (lead != 8'h00) begin
			held = lead;
			lead = 8'h00;
			if (b[7:6] == 2'b10) begin
				emit_codepoint({held[4:0], b[5:0]});
				return;
			end
		end
		if (b >= 8'hC0 && b <= 8'hDF) begin
			lead = b;
			return;
		end
		if (b >= 8'hE0)
			return;
		emit_codepoint({3'b000, b});
	endfunction

	function void report(string what, int expv, int gotv);
		errors++;
		if (errors <= 40)
			$display("%0t %s: expected %0h, got %0h", $time, what, expv, gotv);
	endfunction

	function void check_word(logic [31:0] d, logic fin);
		result_t e;
		checked++;
		if (cmd_q.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t command with none expected: expected nothing, got %h last %b",
				         $time, d, fin);
			return;
		end
		e = cmd_q.pop_front();
		if (e.action == ACT_CLEAR)
			clears++;
		if (e.action != d[0])
			report("action", e.action, d[0]);
		if (e.glyph_table != d[1])
			report("glyph_table", e.glyph_table, d[1]);
		if (e.glyph_index != d[7:2])
			report("glyph_index", e.glyph_index, d[7:2]);
		if (e.pos_x != d[19:8])
			report("pos_x", e.pos_x, d[19:8]);
		if (e.pos_y != d[31:20])
			report("pos_y", e.pos_y, d[31:20]);
		if (e.last != fin)
			report("last", e.last, fin);
	endfunction
endclass

module testbench;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int PH_W [NUM_PHASES] = '{720, 64, 8191, 4096, 16, 300, 0, 0};
	localparam int PH_H [NUM_PHASES] = '{1280, 64, 8191, 4096, 16, 200, 0, 0};
	localparam int PH_S [NUM_PHASES] = '{2, 1, 31, 16, 0, 3, 0, 0};
	localparam int PH_GAP [NUM_PHASES] = '{0, 85, 0, 18, 0, 0, 18, 85};
	localparam int PH_STALL [NUM_PHASES] = '{0, 0, 85, 18, 0, 85, 18, 0};
	localparam int PRESSURE_PHASE = 4;
	localparam logic [7:0] DIRECTED [28] = '{
		8'h41, 8'h61, 8'h7A, 8'h20, 8'h5F, 8'h7E, 8'h00, 8'h7F, 8'h0D, 8'h0A,
		8'hD0, 8'h90, 8'hD1, 8'h8F, 8'hD0, 8'h81, 8'hD1, 8'h91,
		8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hC3, 8'hD0, 8'h90,
		8'h80, 8'hE0, 8'hFF
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = REG_ENABLE;
	logic [12:0] cfg_wdata = 13'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	glyph_cmd_scoreboard sb = new();
	int gap_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int bytes_sent = 0;

	text_console_cursor_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tlast);
	end

	task send_byte(input logic [7:0] b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.cmd_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task write_reg(input cfg_reg_t r, input logic [12:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(r, v);
		@(posedge clk);
	endtask

	task automatic random_traffic(input int n);
		int         sent;
		int         r;
		logic [7:0] c;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send_byte(8'($urandom_range(8'h20, 8'h7E)));
				sent++;
			end else if (r < 60) begin
				case ($urandom_range(0, 3))
					0: begin
						send_byte(8'hD0);
						send_byte(8'($urandom_range(8'h90, 8'hBF)));
					end
					1: begin
						send_byte(8'hD1);
						send_byte(8'($urandom_range(8'h80, 8'h8F)));
					end
					2: begin
						c = $urandom_range(0, 1) ? 8'hD0 : 8'hD1;
						send_byte(c);
						send_byte((c == 8'hD0) ? 8'h81 : 8'h91);
					end
					default: begin
						send_byte($urandom_range(0, 1) ? 8'hD0 : 8'hD1);
						send_byte(8'($urandom_range(8'h80, 8'hBF)));
					end
				endcase
				sent += 2;
			end else if (r < 68) begin
				send_byte(CP_LF[7:0]);
				sent++;
			end else if (r < 73) begin
				send_byte(CP_CR[7:0]);
				sent++;
			end else if (r < 79) begin
				send_byte(8'($urandom_range(8'hC0, 8'hDF)));
				send_byte(8'($urandom_range(8'h80, 8'hBF)));
				sent += 2;
			end else if (r < 85) begin
				send_byte(8'($urandom_range(8'hC0, 8'hDF)));
				c = 8'($urandom_range(0, 191));
				if (c >= 8'h80)
					c = c + 8'h40;
				send_byte(c);
				sent += (c >= 8'hE0) ? 1 : 2;
			end else if (r < 90) begin
				send_byte(8'($urandom_range(8'h80, 8'hBF)));
				sent++;
			end else if (r < 95) begin
				send_byte(8'($urandom_range(0, 8'h1F)));
				sent++;
			end else begin
				c = 8'($urandom_range(0, 255));
				send_byte(c);
				if (c < 8'hE0)
					sent++;
			end
		end
	endtask

	initial begin
		int w;
		int h;
		int s;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k])
			send_byte(DIRECTED[k]);
		send_byte(8'hD0);
		drain();
		write_reg(REG_ENABLE, 13'd0);
		send_byte(8'h41);
		send_byte(CP_LF[7:0]);
		drain();
		write_reg(REG_ENABLE, 13'd1);
		send_byte(8'h90);
		send_byte(8'h21);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			if (p >= 6) begin
				w = $urandom_range(0, 8191);
				h = $urandom_range(0, 8191);
				s = $urandom_range(0, 31);
			end else begin
				w = PH_W[p];
				h = PH_H[p];
				s = PH_S[p];
			end
			write_reg(REG_WIDTH, 13'(w));
			write_reg(REG_HEIGHT, 13'(h));
			write_reg(REG_SCALE, 13'(s));
			gap_pct   = PH_GAP[p];
			stall_pct = PH_STALL[p];
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			random_traffic(PHASE_ITEMS);
		end

		drain();
		$display("summary: %0d bytes over %0d screen setups, %0d commands checked, %0d clears",
		         bytes_sent, NUM_PHASES + 1, sb.checked, sb.clears);
		$display("summary: %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
